>>> src/sphf_pkg.sv
// Shared types, constants and reset values of the SPH pressure and viscosity force block.
package sphf_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int COEFF_FRAC        = 40;
  localparam int IDX_W             = 16;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_NEIGHBOR = 1'b1;

  localparam logic [30:0] H_RST     = 31'd1048576;
  localparam logic [30:0] H2_RST    = 31'd16777216;
  localparam logic [47:0] COEFF_RST = 48'hFFFF_FFCD_10F0;
  localparam logic [30:0] EPS_RST   = 31'd167772;

  typedef enum logic [2:0] {
    CFG_H     = 3'd0,
    CFG_H2    = 3'd1,
    CFG_COEFF = 3'd2,
    CFG_EPS   = 3'd3,
    CFG_GX    = 3'd4,
    CFG_GY    = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT,
    OP_ADD,
    OP_ACC
  } alu_op_t;

  // Right shift applied after a multiply.
  typedef enum logic [1:0] {
    SH_0,
    SH_F,
    SH_C
  } mul_sh_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    mul_sh_t     sh;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic [30:0] h;
    logic [30:0] h2;
    logic [47:0] coeff;
    logic [30:0] eps;
    logic [31:0] gx;
    logic [31:0] gy;
  } cfg_t;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] index;
    logic [31:0]      pos_x;
    logic [31:0]      pos_y;
    logic [31:0]      vel_x;
    logic [31:0]      vel_y;
    logic [30:0]      density;
    logic [30:0]      pressure;
    logic [30:0]      mass;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [31:0]      ax;
    logic [31:0]      ay;
  } emit_t;

endpackage

>>> src/sph_pressure_viscosity_force_top.sv
// Top level of the SPH pressure and viscosity force block: ports, registers, output stage.
//
//   channel  direction  handshake                 payload
//   in_      slave      in_tvalid / in_tready     in_tdata, in_tuser (cmd), in_tlast
//   out_     master     out_tvalid / out_tready   out_tdata
//   cfg_     write      cfg_we                    cfg_index, cfg_wdata
//
// A load word is stored as it is accepted. A neighbor word runs through the shared arithmetic unit:
// two to sixteen multiplies, up to eight divisions and up to three roots, the most when
// viscosity applies. A neighbor outside the cutoff stops after the squared distance; one
// with its own index or a far offset is skipped when it is accepted.
// in_tready is low while a neighbor runs or a result waits to enter the output register.
// The output register holds one result, so the next word is taken while it waits.
// Reset is synchronous, active low, and restores the register defaults.
module sph_pressure_viscosity_force_top
  import sphf_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // particle_index, pos_x, pos_y, vel_x, vel_y, density, pressure, mass, zero pad
  input  logic [239:0] in_tdata,
  // cmd
  input  logic         in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // target_index, accel_x, accel_y
  output logic [79:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_wdata
);

  cfg_t     cfg_r;
  item_t    item;
  emit_t    emit;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     seq_ready, emit_ack;
  logic     out_valid_r;
  logic [79:0] out_data_r;

  assign item.cmd      = in_tuser;
  assign item.index    = in_tdata[15:0];
  assign item.pos_x    = in_tdata[47:16];
  assign item.pos_y    = in_tdata[79:48];
  assign item.vel_x    = in_tdata[111:80];
  assign item.vel_y    = in_tdata[143:112];
  assign item.density  = in_tdata[174:144];
  assign item.pressure = in_tdata[205:175];
  assign item.mass     = in_tdata[236:206];
  assign item.last     = in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.h     <= H_RST;
      cfg_r.h2    <= H2_RST;
      cfg_r.coeff <= COEFF_RST;
      cfg_r.eps   <= EPS_RST;
      cfg_r.gx    <= '0;
      cfg_r.gy    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_H:     cfg_r.h     <= cfg_wdata[30:0];
        CFG_H2:    cfg_r.h2    <= cfg_wdata[30:0];
        CFG_COEFF: cfg_r.coeff <= cfg_wdata;
        CFG_EPS:   cfg_r.eps   <= cfg_wdata[30:0];
        CFG_GX:    cfg_r.gx    <= cfg_wdata[31:0];
        CFG_GY:    cfg_r.gy    <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign emit_ack = emit.valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ack) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {emit.ay, emit.ax, emit.index};
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  sphf_seq #(
    .FRAC(FRACTION_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_accept(in_tvalid && seq_ready),
    .cfg        (cfg_r),
    .ready      (seq_ready),
    .emit       (emit),
    .emit_ack   (emit_ack),
    .alu_req    (alu_req),
    .alu_rsp    (alu_rsp)
  );

  sphf_alu #(
    .FRAC(FRACTION_BITS)
  ) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .rsp  (alu_rsp)
  );

  assign in_tready  = seq_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> src/sphf_alu.sv
// Shared multi-cycle arithmetic unit: multiply, divide, square root and saturating adds.
module sphf_alu
  import sphf_pkg::*;
#(
  parameter int FRAC = FRACTION_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam int DW = 64 + FRAC;
  localparam int CW = $clog2(DW + 1);
  localparam logic [CW-1:0] MUL_STEPS  = CW'(4);
  localparam logic [CW-1:0] SQRT_STEPS = CW'(32);
  localparam logic [CW-1:0] DIV_STEPS  = CW'(DW);
  localparam logic [63:0]   SQ_CAP     = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC;
  localparam logic signed [64:0] SMAX_P = $signed({1'b0, SMAX});
  localparam logic signed [64:0] SMAX_N = -$signed({1'b0, SMAX});
  localparam logic signed [64:0] A40_P  = 65'sd549755813887;
  localparam logic signed [64:0] A40_N  = -65'sd549755813888;

  logic          busy_r, done_r, neg_r;
  alu_op_t       op_r;
  mul_sh_t       sh_r;
  logic [CW-1:0] cnt_r;
  logic [63:0]   ua_r, ub_r, res_r;
  logic [127:0]  prod_r;
  logic [DW-1:0] quo_r;
  logic [63:0]   rem_r, den_r;
  logic [63:0]   sx_r, sr_r, sbit_r;

  logic [63:0]   mag_a, mag_b;
  logic [1:0]    ph;
  logic [31:0]   ah, bh;
  logic [63:0]   pp;
  logic [127:0]  pp_sh, prod_s;
  logic          mul_sat, div_sat;
  logic [63:0]   mul_res, div_res;
  logic [64:0]   rem_sh;
  logic          q_bit;
  logic [63:0]   rem_new;
  logic [63:0]   s_sum;
  logic          s_ge;
  logic signed [64:0] sum65;
  logic [63:0]   add_res, acc_res;
  logic [63:0]   sq_u, sq_x0;

  assign mag_a = req.a[63] ? (64'd0 - req.a) : req.a;
  assign mag_b = req.b[63] ? (64'd0 - req.b) : req.b;

  // Partial products, high halves first as the count runs down.
  assign ph = 2'(cnt_r - CW'(1));
  assign ah = ph[0] ? ua_r[63:32] : ua_r[31:0];
  assign bh = ph[1] ? ub_r[63:32] : ub_r[31:0];
  assign pp = ah * bh;

  always_comb begin
    case (ph)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    case (sh_r)
      SH_F:    prod_s = prod_r >> FRAC;
      SH_C:    prod_s = prod_r >> COEFF_FRAC;
      default: prod_s = prod_r;
    endcase
  end

  assign mul_sat = |prod_s[127:63];
  assign mul_res = mul_sat ? (neg_r ? (64'd0 - SMAX) : SMAX)
                           : (neg_r ? (64'd0 - prod_s[63:0]) : prod_s[63:0]);

  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign q_bit   = rem_sh >= {1'b0, den_r};
  assign rem_new = q_bit ? 64'(rem_sh - {1'b0, den_r}) : rem_sh[63:0];
  assign div_sat = |quo_r[DW-1:63];
  assign div_res = div_sat ? (neg_r ? (64'd0 - SMAX) : SMAX)
                           : (neg_r ? (64'd0 - quo_r[63:0]) : quo_r[63:0]);

  assign s_sum = sr_r + sbit_r;
  assign s_ge  = sx_r >= s_sum;

  assign sum65 = $signed({req.a[63], req.a}) + $signed({req.b[63], req.b});

  always_comb begin
    if (sum65 > SMAX_P) begin
      add_res = SMAX;
    end else if (sum65 < SMAX_N) begin
      add_res = 64'd0 - SMAX;
    end else begin
      add_res = sum65[63:0];
    end
    if (sum65 > A40_P) begin
      acc_res = A40_P[63:0];
    end else if (sum65 < A40_N) begin
      acc_res = A40_N[63:0];
    end else begin
      acc_res = sum65[63:0];
    end
  end

  assign sq_u  = req.a[63] ? 64'd0 : ((req.a > SQ_CAP) ? SQ_CAP : req.a);
  assign sq_x0 = sq_u << FRAC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        op_r <= req.op;
        sh_r <= req.sh;
        unique case (req.op)
          OP_MUL: begin
            busy_r <= 1'b1;
            cnt_r  <= MUL_STEPS;
            ua_r   <= mag_a;
            ub_r   <= mag_b;
            prod_r <= '0;
            neg_r  <= req.a[63] ^ req.b[63];
          end
          OP_DIV: begin
            busy_r <= 1'b1;
            cnt_r  <= DIV_STEPS;
            quo_r  <= {mag_a, {FRAC{1'b0}}};
            den_r  <= (req.b == 64'd0) ? 64'd1 : req.b;
            rem_r  <= '0;
            neg_r  <= req.a[63];
          end
          OP_SQRT: begin
            busy_r <= 1'b1;
            cnt_r  <= SQRT_STEPS;
            sx_r   <= sq_x0;
            sr_r   <= '0;
            sbit_r <= 64'h4000_0000_0000_0000;
          end
          OP_ADD: begin
            res_r  <= add_res;
            done_r <= 1'b1;
          end
          OP_ACC: begin
            res_r  <= acc_res;
            done_r <= 1'b1;
          end
          default: begin
            done_r <= 1'b1;
          end
        endcase
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - CW'(1);
          case (op_r)
            OP_MUL: prod_r <= prod_r + pp_sh;
            OP_DIV: begin
              quo_r <= {quo_r[DW-2:0], q_bit};
              rem_r <= rem_new;
            end
            OP_SQRT: begin
              if (s_ge) begin
                sx_r <= sx_r - s_sum;
                sr_r <= (sr_r >> 1) + sbit_r;
              end else begin
                sr_r <= sr_r >> 1;
              end
              sbit_r <= sbit_r >> 2;
            end
            default: ;
          endcase
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          case (op_r)
            OP_MUL:  res_r <= mul_res;
            OP_DIV:  res_r <= div_res;
            OP_SQRT: res_r <= sr_r;
            default: res_r <= res_r;
          endcase
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

>>> src/sphf_seq.sv
// Sequencer and working registers: particle state, per-neighbor steps and accumulators.
module sphf_seq
  import sphf_pkg::*;
#(
  parameter int FRAC = FRACTION_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  item_t    item,
  input  logic     item_accept,
  input  cfg_t     cfg,
  output logic     ready,
  output emit_t    emit,
  input  logic     emit_ack,
  output alu_req_t alu_req,
  input  alu_rsp_t alu_rsp
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_t;

  typedef enum logic [5:0] {
    S_RXX, S_RYY, S_D2, S_DIST, S_DX, S_DY, S_HR, S_HR2, S_G,
    S_AI1, S_AI, S_AJ1, S_AJ, S_PT, S_MP, S_T, S_FX, S_AX, S_FY, S_AY,
    S_VX, S_VY, S_VD, S_CI, S_CJ, S_HV, S_MU, S_CM, S_PI, S_MPI, S_T2,
    S_FX2, S_AX2, S_FY2, S_AY2
  } step_t;

  state_t           state_r;
  step_t            step_r;
  logic             wait_r, last_r;
  logic [IDX_W-1:0] self_idx_r;
  logic [31:0]      spx_r, spy_r, svx_r, svy_r;
  logic [30:0]      srho_r, sp_r;
  logic [39:0]      accx_r, accy_r;
  logic [31:0]      rx_r, ry_r;
  logic [32:0]      dvx_r, dvy_r;
  logic [30:0]      pj_r, rhoj_r, m_r;
  logic [63:0]      t0_r, t1_r, d2_r, dist_r, dx_r, dy_r, g_r;
  logic [63:0]      ai1_r, aj1_r, ai_r, aj_r, ci_r, cj_r, vd_r;

  logic [32:0] rx_c, ry_c;
  logic        far_x, far_y, skip;
  logic [63:0] res, d2v, rx64, ry64;

  function automatic logic [31:0] clamp32(logic signed [40:0] v);
    if (v > 41'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -41'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  assign rx_c  = {spx_r[31], spx_r} - {item.pos_x[31], item.pos_x};
  assign ry_c  = {spy_r[31], spy_r} - {item.pos_y[31], item.pos_y};
  // In range only strictly inside (-2^31, 2^31).
  assign far_x = !((rx_c[32:31] == 2'b00) || ((rx_c[32:31] == 2'b11) && (rx_c[30:0] != '0)));
  assign far_y = !((ry_c[32:31] == 2'b00) || ((ry_c[32:31] == 2'b11) && (ry_c[30:0] != '0)));
  assign skip  = far_x || far_y || (item.index == self_idx_r);

  assign res  = alu_rsp.res;
  assign d2v  = res >> FRAC;
  assign rx64 = {{32{rx_r[31]}}, rx_r};
  assign ry64 = {{32{ry_r[31]}}, ry_r};

  always_comb begin
    alu_req.start = (state_r == ST_RUN) && !wait_r;
    alu_req.op    = OP_MUL;
    alu_req.sh    = SH_F;
    alu_req.a     = '0;
    alu_req.b     = '0;
    unique case (step_r)
      S_RXX: begin alu_req.sh = SH_0; alu_req.a = rx64; alu_req.b = rx64; end
      S_RYY: begin alu_req.sh = SH_0; alu_req.a = ry64; alu_req.b = ry64; end
      S_D2:  begin alu_req.op = OP_ADD; alu_req.a = t0_r; alu_req.b = t1_r; end
      S_DIST: begin alu_req.op = OP_SQRT; alu_req.a = d2_r; end
      S_DX:  begin alu_req.op = OP_DIV; alu_req.a = rx64; alu_req.b = dist_r; end
      S_DY:  begin alu_req.op = OP_DIV; alu_req.a = ry64; alu_req.b = dist_r; end
      S_HR: begin
        alu_req.op = OP_ADD;
        alu_req.a  = {33'd0, cfg.h};
        alu_req.b  = 64'd0 - dist_r;
      end
      S_HR2: begin alu_req.a = t0_r; alu_req.b = t0_r; end
      S_G: begin
        alu_req.sh = SH_C;
        alu_req.a  = {{16{cfg.coeff[47]}}, cfg.coeff};
        alu_req.b  = t0_r;
      end
      S_AI1: begin alu_req.op = OP_DIV; alu_req.a = {33'd0, sp_r};  alu_req.b = {33'd0, srho_r}; end
      S_AI:  begin alu_req.op = OP_DIV; alu_req.a = ai1_r;          alu_req.b = {33'd0, srho_r}; end
      S_AJ1: begin alu_req.op = OP_DIV; alu_req.a = {33'd0, pj_r};  alu_req.b = {33'd0, rhoj_r}; end
      S_AJ:  begin alu_req.op = OP_DIV; alu_req.a = aj1_r;          alu_req.b = {33'd0, rhoj_r}; end
      S_PT:  begin alu_req.op = OP_ADD; alu_req.a = ai_r; alu_req.b = aj_r; end
      S_MP:  begin alu_req.a = {33'd0, m_r}; alu_req.b = 64'd0 - t0_r; end
      S_T, S_T2: begin alu_req.a = t0_r; alu_req.b = g_r; end
      S_FX, S_FX2: begin alu_req.a = t1_r; alu_req.b = dx_r; end
      S_FY, S_FY2: begin alu_req.a = t1_r; alu_req.b = dy_r; end
      S_AX: begin alu_req.op = OP_ACC; alu_req.a = {{24{accx_r[39]}}, accx_r}; alu_req.b = t0_r; end
      S_AY: begin alu_req.op = OP_ACC; alu_req.a = {{24{accy_r[39]}}, accy_r}; alu_req.b = t0_r; end
      S_AX2: begin
        alu_req.op = OP_ACC;
        alu_req.a  = {{24{accx_r[39]}}, accx_r};
        alu_req.b  = 64'd0 - t0_r;
      end
      S_AY2: begin
        alu_req.op = OP_ACC;
        alu_req.a  = {{24{accy_r[39]}}, accy_r};
        alu_req.b  = 64'd0 - t0_r;
      end
      S_VX: begin alu_req.a = {{31{dvx_r[32]}}, dvx_r}; alu_req.b = rx64; end
      S_VY: begin alu_req.a = {{31{dvy_r[32]}}, dvy_r}; alu_req.b = ry64; end
      S_VD: begin alu_req.op = OP_ADD; alu_req.a = t0_r; alu_req.b = t1_r; end
      S_CI: begin alu_req.op = OP_SQRT; alu_req.a = ai1_r; end
      S_CJ: begin alu_req.op = OP_SQRT; alu_req.a = aj1_r; end
      S_HV: begin alu_req.a = {33'd0, cfg.h}; alu_req.b = vd_r; end
      S_MU: begin
        alu_req.op = OP_DIV;
        alu_req.a  = t0_r;
        alu_req.b  = d2_r + {33'd0, cfg.eps};
      end
      S_CM: begin alu_req.a = (ci_r + cj_r) >> 1; alu_req.b = t1_r; end
      S_PI: begin
        alu_req.op = OP_DIV;
        alu_req.a  = 64'd0 - t0_r;
        alu_req.b  = {32'd0, ({1'b0, srho_r} + {1'b0, rhoj_r})} >> 1;
      end
      S_MPI: begin alu_req.a = {33'd0, m_r}; alu_req.b = t0_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= S_RXX;
      wait_r     <= 1'b0;
      last_r     <= 1'b0;
      self_idx_r <= '0;
      spx_r      <= '0;
      spy_r      <= '0;
      svx_r      <= '0;
      svy_r      <= '0;
      srho_r     <= 31'd1;
      sp_r       <= '0;
      accx_r     <= '0;
      accy_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (item_accept) begin
            last_r <= item.last;
            if (item.cmd == CMD_LOAD) begin
              self_idx_r <= item.index;
              spx_r      <= item.pos_x;
              spy_r      <= item.pos_y;
              svx_r      <= item.vel_x;
              svy_r      <= item.vel_y;
              srho_r     <= (item.density == '0) ? 31'd1 : item.density;
              sp_r       <= item.pressure;
              accx_r     <= '0;
              accy_r     <= '0;
              state_r    <= item.last ? ST_EMIT : ST_IDLE;
            end else begin
              rx_r    <= rx_c[31:0];
              ry_r    <= ry_c[31:0];
              dvx_r   <= {svx_r[31], svx_r} - {item.vel_x[31], item.vel_x};
              dvy_r   <= {svy_r[31], svy_r} - {item.vel_y[31], item.vel_y};
              pj_r    <= item.pressure;
              rhoj_r  <= (item.density == '0) ? 31'd1 : item.density;
              m_r     <= item.mass;
              step_r  <= S_RXX;
              wait_r  <= 1'b0;
              state_r <= skip ? (item.last ? ST_EMIT : ST_IDLE) : ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (alu_rsp.done) begin
            wait_r <= 1'b0;
            step_r <= step_t'(step_r + 6'd1);
            case (step_r)
              S_RXX, S_HR, S_PT, S_MP, S_FX, S_FY, S_VX, S_HV, S_CM, S_PI, S_MPI,
              S_FX2, S_FY2: t0_r <= res;
              S_RYY, S_T, S_VY, S_MU, S_T2: t1_r <= res;
              S_HR2: t0_r <= res;
              S_D2: begin
                d2_r <= d2v;
                if ((d2v >= {33'd0, cfg.h2}) || (d2v == '0)) begin
                  state_r <= last_r ? ST_EMIT : ST_IDLE;
                end
              end
              S_DIST: dist_r <= res;
              S_DX:   dx_r   <= res;
              S_DY:   dy_r   <= res;
              S_G:    g_r    <= res;
              S_AI1:  ai1_r  <= res;
              S_AI:   ai_r   <= res;
              S_AJ1:  aj1_r  <= res;
              S_AJ:   aj_r   <= res;
              S_AX:   accx_r <= res[39:0];
              S_AY:   accy_r <= res[39:0];
              S_AX2:  accx_r <= res[39:0];
              S_VD: begin
                vd_r <= res;
                // Separating pairs get no viscosity.
                if (!res[63]) begin
                  state_r <= last_r ? ST_EMIT : ST_IDLE;
                end
              end
              S_CI:   ci_r   <= res;
              S_CJ:   cj_r   <= res;
              S_AY2: begin
                accy_r  <= res[39:0];
                state_r <= last_r ? ST_EMIT : ST_IDLE;
              end
              default: ;
            endcase
          end
        end
        ST_EMIT: begin
          if (emit_ack) begin
            accx_r  <= '0;
            accy_r  <= '0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign ready      = (state_r == ST_IDLE);
  assign emit.valid = (state_r == ST_EMIT);
  assign emit.index = self_idx_r;
  assign emit.ax    = clamp32($signed({accx_r[39], accx_r}) +
                              $signed({{9{cfg.gx[31]}}, cfg.gx}));
  assign emit.ay    = clamp32($signed({accy_r[39], accy_r}) +
                              $signed({{9{cfg.gy[31]}}, cfg.gy}));

endmodule

>>> src/sphf_chk.sv
// Port-level checker for the SPH force block, bound to the top level.
module sphf_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [239:0] in_tdata,
  input logic         in_tuser,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [79:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // A load word that does not end a run leaves the block ready at once.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !in_tlast |=> in_tready)
    else $error("not ready after a load word");

  // A load word that ends a run reports gravity for that particle through the emit state and the output register.
  a_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && in_tlast && !out_tvalid |->
      ##2 (out_tvalid && (out_tdata[15:0] == $past(in_tdata[15:0], 2))))
    else $error("load with last gave no result for its particle");

endmodule

bind sph_pressure_viscosity_force_top sphf_chk u_sphf_chk (.*);

>>> sim/sph_pressure_viscosity_force_top_test.sv
// Testbench for the SPH pressure and viscosity force block: self-checking, random stimulus.
module sph_pressure_viscosity_force_top_test;
  import sphf_pkg::*;

  localparam int FB = 16;
  localparam logic [63:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [15:0] idx;
    logic [31:0] ax;
    logic [31:0] ay;
  } accel_t;

  int errors = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Predicts the acceleration words and holds them until the block returns them.
  class accel_board;
    logic [30:0] h = H_RST, h2 = H2_RST, eps = EPS_RST;
    logic [47:0] coeff = COEFF_RST;
    logic [31:0] gx = '0, gy = '0;
    logic [15:0] s_idx = '0;
    longint s_px = 0, s_py = 0, s_vx = 0, s_vy = 0, s_rho = 1, s_p = 0;
    longint acc_x = 0, acc_y = 0;
    accel_t pending[$];

    function void write_reg(cfg_idx_t i, logic [47:0] v);
      case (i)
        CFG_H: h = v[30:0];
        CFG_H2: h2 = v[30:0];
        CFG_COEFF: coeff = v;
        CFG_EPS: eps = v[30:0];
        CFG_GX: gx = v[31:0];
        default: gy = v[31:0];
      endcase
    endfunction

    function longint sadd(longint a, longint b);
      if (b > 0 && a > longint'(S_MAX) - b) return longint'(S_MAX);
      if (b < 0 && a < -longint'(S_MAX) - b) return -longint'(S_MAX);
      return a + b;
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint fmul(longint a, longint b, int s);
      logic [127:0] p;
      logic [63:0] ua, ub;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = ({64'b0, ua} * {64'b0, ub}) >> s;
      if (p > {64'b0, S_MAX}) return neg ? -longint'(S_MAX) : longint'(S_MAX);
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function longint fdiv(longint num, logic [63:0] den);
      logic [63:0] un, q, r, res;
      bit neg;
      neg = num < 0;
      un = num < 0 ? -num : num;
      if (den == 0) den = 1;
      q = un / den;
      r = un % den;
      if (q > (S_MAX >> FB)) return neg ? -longint'(S_MAX) : longint'(S_MAX);
      res = (q << FB) + (r << FB) / den;
      return neg ? -longint'(res) : longint'(res);
    endfunction

    function logic [63:0] root(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function longint qroot(longint x);
      logic [63:0] u;
      u = x < 0 ? 0 : x;
      if (u > (64'hFFFF_FFFF_FFFF_FFFF >> FB)) u = 64'hFFFF_FFFF_FFFF_FFFF >> FB;
      return longint'(root(u << FB));
    endfunction

    function void add_acc(longint vx, longint vy);
      acc_x = clamp(sadd(acc_x, vx), 40);
      acc_y = clamp(sadd(acc_y, vy), 40);
    endfunction

    function void neighbor(item_t it);
      longint rx, ry, rlen, dx, dy, hr, g, ai, aj, t, vdot, m, ci, cj, mu, pv;
      logic [63:0] d2, rho_j, ux, uy;
      rho_j = it.density;
      m = it.mass;
      if (it.index == s_idx) return;
      rx = s_px - longint'($signed(it.pos_x));
      ry = s_py - longint'($signed(it.pos_y));
      ux = rx < 0 ? -rx : rx;
      uy = ry < 0 ? -ry : ry;
      if (ux >= 64'h8000_0000 || uy >= 64'h8000_0000) return;
      d2 = (ux * ux + uy * uy) >> FB;
      if (d2 >= h2 || d2 == 0) return;
      if (rho_j == 0) rho_j = 1;
      rlen = longint'(root(d2 << FB));
      dx = rx * (longint'(1) << FB) / rlen;
      dy = ry * (longint'(1) << FB) / rlen;
      hr = longint'(h) - rlen;
      g = fmul(longint'($signed(coeff)), fmul(hr, hr, FB), COEFF_FRAC);
      ai = fdiv(fdiv(s_p, s_rho), s_rho);
      aj = fdiv(fdiv(longint'(it.pressure), rho_j), rho_j);
      t = fmul(fmul(m, -sadd(ai, aj), FB), g, FB);
      add_acc(fmul(t, dx, FB), fmul(t, dy, FB));
      vdot = sadd(fmul(s_vx - longint'($signed(it.vel_x)), rx, FB),
                  fmul(s_vy - longint'($signed(it.vel_y)), ry, FB));
      if (vdot < 0) begin
        ci = qroot(fdiv(s_p, s_rho));
        cj = qroot(fdiv(longint'(it.pressure), rho_j));
        mu = fdiv(fmul(longint'(h), vdot, FB), d2 + eps);
        pv = fdiv(-fmul((ci + cj) / 2, mu, FB), (s_rho + rho_j) >> 1);
        t = fmul(fmul(m, pv, FB), g, FB);
        add_acc(-fmul(t, dx, FB), -fmul(t, dy, FB));
      end
    endfunction

    function void note_input(item_t it);
      accel_t e;
      if (it.cmd == CMD_LOAD) begin
        s_idx = it.index;
        s_px = $signed(it.pos_x);
        s_py = $signed(it.pos_y);
        s_vx = $signed(it.vel_x);
        s_vy = $signed(it.vel_y);
        s_rho = it.density == 0 ? 1 : it.density;
        s_p = it.pressure;
        acc_x = 0;
        acc_y = 0;
      end else neighbor(it);
      if (it.last) begin
        e.idx = s_idx;
        e.ax = clamp(acc_x + longint'($signed(gx)), 32);
        e.ay = clamp(acc_y + longint'($signed(gy)), 32);
        pending.push_back(e);
        acc_x = 0;
        acc_y = 0;
      end
    endfunction

    task check_result(logic [79:0] d);
      accel_t e;
      if (pending.size() == 0) begin
        report("unexpected word", d[63:0], 0);
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.idx) report("target_index", d[15:0], e.idx);
      if (d[47:16] !== e.ax) report("accel_x", d[47:16], e.ax);
      if (d[79:48] !== e.ay) report("accel_y", d[79:48], e.ay);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, in_tlast = 0, in_tready;
  logic [239:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [79:0] out_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_wdata = '0;
  bit stim_done = 0;
  int hold_off = 0;
  accel_board board = new();

  sph_pressure_viscosity_force_top dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // The caller drops cfg_we after its last write.
  task automatic write_cfg(cfg_idx_t i, logic [47:0] v);
    cfg_we <= 1;
    cfg_index <= i;
    cfg_wdata <= v;
    @(posedge clk);
    board.write_reg(i, v);
  endtask

  // in_tvalid stays high after the accepting edge so that a word with no gap follows at once.
  task automatic send(item_t it);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= it.cmd;
    in_tlast <= it.last;
    in_tdata <= {3'b0, it.mass, it.pressure, it.density, it.vel_y, it.vel_x,
                 it.pos_y, it.pos_x, it.index};
    do @(posedge clk); while (!in_tready);
    board.note_input(it);
  endtask

  // Values within a few h of the target, so that some neighbors land inside the cutoff.
  function automatic logic [31:0] near(logic [31:0] c, int span);
    return c + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [30:0] r31(bit wide);
    return wide ? 31'($urandom()) : 31'($urandom_range(0, 32'h0020_0000));
  endfunction

  function automatic item_t make_load(logic [15:0] idx, bit last);
    item_t it;
    it.cmd = CMD_LOAD;
    it.index = idx;
    it.pos_x = $urandom_range(0, 3) == 0 ? $urandom() : $signed($urandom_range(0, 1 << 22));
    it.pos_y = $urandom_range(0, 3) == 0 ? $urandom() : $signed($urandom_range(0, 1 << 22));
    it.vel_x = $urandom();
    it.vel_y = $urandom();
    it.vel_x = $urandom_range(0, 1) ? it.vel_x : near(0, 1 << 18);
    it.vel_y = $urandom_range(0, 1) ? it.vel_y : near(0, 1 << 18);
    it.density = $urandom_range(0, 7) == 0 ? 0 : r31($urandom_range(0, 3) == 0);
    it.pressure = r31($urandom_range(0, 3) == 0);
    it.mass = 31'($urandom());
    it.last = last;
    return it;
  endfunction

  function automatic item_t make_nb(item_t tgt, bit last);
    item_t it;
    it = make_load($urandom_range(0, 15) == 0 ? tgt.index : 16'($urandom()), last);
    it.cmd = CMD_NEIGHBOR;
    if ($urandom_range(0, 7) != 0) begin
      it.pos_x = near(tgt.pos_x, 1 << 21);
      it.pos_y = near(tgt.pos_y, 1 << 21);
    end
    if ($urandom_range(0, 15) == 0) begin
      it.pos_x = tgt.pos_x;
      it.pos_y = tgt.pos_y;
    end
    it.mass = r31($urandom_range(0, 3) == 0);
    return it;
  endfunction

  task automatic run_cluster();
    item_t tgt;
    int n;
    tgt = make_load(16'($urandom()), $urandom_range(0, 9) == 0);
    send(tgt);
    n = $urandom_range(0, 6);
    for (int k = 0; k < n; k++) send(make_nb(tgt, k == n - 1 || $urandom_range(0, 19) == 0));
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic phase_cfg(bit extreme);
    if (extreme) begin
      write_cfg(CFG_H, $urandom_range(0, 1) ? 48'h7FFF_FFFF : 48'h0);
      write_cfg(CFG_H2, 48'h7FFF_FFFF);
      write_cfg(CFG_COEFF, $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000);
      write_cfg(CFG_EPS, $urandom_range(0, 1) ? 48'h7FFF_FFFF : 48'h0);
      write_cfg(CFG_GX, $urandom_range(0, 1) ? 48'h7FFF_FFFF : 48'h8000_0000);
      write_cfg(CFG_GY, $urandom_range(0, 1) ? 48'h7FFF_FFFF : 48'h8000_0000);
    end else begin
      write_cfg(CFG_H, $urandom_range(1 << 19, 1 << 22));
      write_cfg(CFG_H2, $urandom_range(1 << 22, 1 << 27));
      write_cfg(CFG_COEFF, {$urandom(), 16'($urandom())} >>> $urandom_range(8, 24));
      write_cfg(CFG_EPS, $urandom_range(0, 1 << 20));
      write_cfg(CFG_GX, $urandom_range(0, 1) ? 32'($urandom()) : near(0, 1 << 18));
      write_cfg(CFG_GY, $urandom_range(0, 1) ? 32'($urandom()) : near(0, 1 << 18));
    end
    cfg_we <= 0;
  endtask

  initial begin
    item_t t, n;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Neighbor before any load, last on a load, zero density, self and coincident cases.
    t = make_load(16'h1, 0);
    t.pos_x = 0;
    t.pos_y = 0;
    n = make_nb(t, 1);
    n.index = 16'h7;
    n.pos_x = 32'h0000_8000;
    n.pos_y = 32'hFFFF_8000;
    send(n);
    t = make_load(16'hFFFF, 1);
    t.density = 0;
    send(t);
    t.last = 0;
    t.pressure = 31'h7FFF_FFFF;
    send(t);
    n.index = t.index;
    n.last = 0;
    send(n);
    n.index = 16'h0;
    n.pos_x = t.pos_x;
    n.pos_y = t.pos_y;
    send(n);
    n.pos_x = t.pos_x ^ 32'h8000_0000;
    send(n);
    n = make_nb(t, 0);
    n.index = 16'h2;
    n.pos_x = t.pos_x + 32'h0001_0000;
    n.pos_y = t.pos_y;
    n.vel_x = 32'h8000_0000;
    n.vel_y = 32'h7FFF_FFFF;
    n.density = 0;
    n.pressure = 31'h7FFF_FFFF;
    n.mass = 31'h7FFF_FFFF;
    send(n);
    n.vel_x = 32'h7FFF_FFFF;
    n.density = 31'h7FFF_FFFF;
    n.pressure = 0;
    n.last = 1;
    send(n);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      phase_cfg(ph == 2 || ph == 5);
      for (int c = 0; c < 35; c++) run_cluster();
      if (ph == 3) begin
        hold_off = 4000;
        for (int c = 0; c < 10; c++) run_cluster();
      end
      drain();
    end
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_tready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      out_tready <= 0;
      repeat (w) @(posedge clk);
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    wait (stim_done);
    if (errors == 0 && board.pending.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

>>> sph_pressure_viscosity_force_top.f
src/sphf_pkg.sv
src/sphf_alu.sv
src/sphf_seq.sv
src/sph_pressure_viscosity_force_top.sv
src/sphf_chk.sv
sim/sph_pressure_viscosity_force_top_test.sv
